// File: hw/rtl/mss_pkg.sv
// Shared types and constants for the motion safety supervisor.
package mss_pkg;

    // Event codes carried on the func field
    localparam logic [2:0] FUNC_REQUEST = 3'd0;
    localparam logic [2:0] FUNC_ENABLE  = 3'd1;
    localparam logic [2:0] FUNC_STOP    = 3'd2;
    localparam logic [2:0] FUNC_FAULT   = 3'd3;
    localparam logic [2:0] FUNC_BATTERY = 3'd4;
    localparam logic [2:0] FUNC_TICK    = 3'd5;

    // Mode codes as reported on mode_code
    localparam logic [2:0] MODE_SAFE_STOPPED = 3'd0;
    localparam logic [2:0] MODE_READY        = 3'd1;
    localparam logic [2:0] MODE_MOVING       = 3'd2;
    localparam logic [2:0] MODE_LIMITED      = 3'd3;
    localparam logic [2:0] MODE_STOPPING     = 3'd4;
    localparam logic [2:0] MODE_FAULT        = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_LINEAR    = 2'd0;
    localparam logic [1:0] CFG_MAX_ANGULAR   = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

    localparam logic [14:0] MAX_LINEAR_RST    = 15'd4096;
    localparam logic [14:0] MAX_ANGULAR_RST   = 15'd4096;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd25;

    // Status portion of one result
    typedef struct packed {
        logic       command_valid;
        logic [2:0] mode_code;
        logic       success;
    } t_step_res;

endpackage

// File: hw/rtl/motion_safety_supervisor_core.sv
// Motion safety supervisor: gates motion requests by mode, limits and watchdog.
// Each event transaction gives exactly one result transaction. An event is
// registered on input, evaluated against the mode, battery flag and request
// age, and the result is registered on output: an accepted event passes the
// input register and then the result register, and one event per cycle is
// taken as long as results are drained. A stalled output holds one result
// while one more event waits in the input register. Configuration writes
// (limits, timeout) take effect at once and are meant for an idle block.
module motion_safety_supervisor_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_func,
    input  logic signed [15:0] i_linear_in,
    input  logic signed [15:0] i_angular_in,
    input  logic               i_battery_valid,
    input  logic signed [10:0] i_charge_tenths,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_command_valid,
    output logic signed [15:0] o_linear_cmd,
    output logic signed [15:0] o_angular_cmd,
    output logic [2:0]         o_mode_code,
    output logic               o_success,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import mss_pkg::*;

    logic [14:0] r_max_linear;
    logic [14:0] r_max_angular;
    logic [15:0] r_timeout_ticks;

    // input register
    logic               r_in_valid;
    logic [2:0]         r_func;
    logic signed [15:0] r_linear_in;
    logic signed [15:0] r_angular_in;
    logic               r_battery_valid;
    logic signed [10:0] r_charge_tenths;

    // result register
    logic               r_out_valid;
    t_step_res          r_res;
    logic signed [15:0] r_linear_cmd;
    logic signed [15:0] r_angular_cmd;

    t_step_res          step_res;
    logic signed [15:0] step_lin;
    logic signed [15:0] step_ang;
    logic               out_free;
    logic               fire;
    logic               in_take;

    assign out_free   = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;
    assign in_take    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_linear    <= MAX_LINEAR_RST;
            r_max_angular   <= MAX_ANGULAR_RST;
            r_timeout_ticks <= TIMEOUT_TICKS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_LINEAR:    r_max_linear    <= i_cfg_data[14:0];
                CFG_MAX_ANGULAR:   r_max_angular   <= i_cfg_data[14:0];
                CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_func          <= i_func;
            r_linear_in     <= i_linear_in;
            r_angular_in    <= i_angular_in;
            r_battery_valid <= i_battery_valid;
            r_charge_tenths <= i_charge_tenths;
        end
    end

    mss_step u_step (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_func          (r_func),
        .i_linear_in     (r_linear_in),
        .i_angular_in    (r_angular_in),
        .i_battery_valid (r_battery_valid),
        .i_charge_tenths (r_charge_tenths),
        .i_max_linear    (r_max_linear),
        .i_max_angular   (r_max_angular),
        .i_timeout_ticks (r_timeout_ticks),
        .o_res           (step_res),
        .o_linear_cmd    (step_lin),
        .o_angular_cmd   (step_ang)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res         <= step_res;
            r_linear_cmd  <= step_lin;
            r_angular_cmd <= step_ang;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_command_valid = r_res.command_valid;
    assign o_mode_code     = r_res.mode_code;
    assign o_success       = r_res.success;
    assign o_linear_cmd    = r_linear_cmd;
    assign o_angular_cmd   = r_angular_cmd;
endmodule

// File: hw/rtl/mss_clamp.sv
// Symmetric clamp of a signed Q3.12 value to +/- an unsigned limit.
module mss_clamp (
    input  logic signed [15:0] i_value,
    input  logic        [14:0] i_limit,
    output logic signed [15:0] o_value
);
    logic signed [16:0] value_x;
    logic signed [16:0] pos_lim;
    logic signed [16:0] neg_lim;

    assign value_x = {i_value[15], i_value};
    assign pos_lim = {2'b00, i_limit};
    assign neg_lim = -pos_lim;

    always_comb begin
        if (value_x > pos_lim) begin
            o_value = pos_lim[15:0];
        end else if (value_x < neg_lim) begin
            o_value = neg_lim[15:0];
        end else begin
            o_value = i_value;
        end
    end
endmodule

// File: hw/rtl/mss_step.sv
// Event handling: mode, battery flag and request age, plus the command for one event.
module mss_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [2:0]          i_func,
    input  logic signed [15:0]  i_linear_in,
    input  logic signed [15:0]  i_angular_in,
    input  logic                i_battery_valid,
    input  logic signed [10:0]  i_charge_tenths,
    input  logic [14:0]         i_max_linear,
    input  logic [14:0]         i_max_angular,
    input  logic [15:0]         i_timeout_ticks,
    output mss_pkg::t_step_res  o_res,
    output logic signed [15:0]  o_linear_cmd,
    output logic signed [15:0]  o_angular_cmd
);
    import mss_pkg::*;

    logic [2:0]  r_mode;
    logic [2:0]  n_mode;
    logic        r_batt_crit;
    logic        n_batt_crit;
    logic [15:0] r_ticks;
    logic [15:0] n_ticks;

    logic signed [15:0] lin_clamped;
    logic signed [15:0] ang_clamped;
    logic               enabled;
    logic               is_moving;
    logic [15:0]        ticks_inc;

    mss_clamp u_clamp_lin (
        .i_value (i_linear_in),
        .i_limit (i_max_linear),
        .o_value (lin_clamped)
    );

    mss_clamp u_clamp_ang (
        .i_value (i_angular_in),
        .i_limit (i_max_angular),
        .o_value (ang_clamped)
    );

    // limited counts as moving, stopping counts as enabled
    assign enabled   = (r_mode != MODE_SAFE_STOPPED) && (r_mode != MODE_FAULT);
    assign is_moving = (r_mode == MODE_MOVING) || (r_mode == MODE_LIMITED);
    assign ticks_inc = (r_ticks == 16'hFFFF) ? r_ticks : r_ticks + 16'd1;

    always_comb begin
        n_mode              = r_mode;
        n_batt_crit         = r_batt_crit;
        n_ticks             = r_ticks;
        o_res.command_valid = 1'b0;
        o_res.success       = 1'b1;
        o_linear_cmd        = '0;
        o_angular_cmd       = '0;
        case (i_func)
            FUNC_REQUEST: begin
                n_ticks             = '0;
                o_res.command_valid = 1'b1;
                if (enabled) begin
                    o_linear_cmd  = lin_clamped;
                    o_angular_cmd = ang_clamped;
                    n_mode = ((lin_clamped == 16'sd0) && (ang_clamped == 16'sd0))
                             ? MODE_READY : MODE_MOVING;
                end
            end
            FUNC_ENABLE: begin
                if (r_mode == MODE_FAULT) begin
                    o_res.success = 1'b0;
                end else begin
                    n_mode = MODE_READY;
                end
            end
            FUNC_STOP: begin
                n_mode              = MODE_SAFE_STOPPED;
                o_res.command_valid = 1'b1;
            end
            FUNC_FAULT: begin
                n_mode              = MODE_FAULT;
                o_res.command_valid = 1'b1;
            end
            FUNC_BATTERY: begin
                n_batt_crit = i_battery_valid &&
                              (i_charge_tenths[10] || (i_charge_tenths == 11'sd0));
            end
            FUNC_TICK: begin
                n_ticks = ticks_inc;
                if (is_moving && (r_batt_crit || (ticks_inc > i_timeout_ticks))) begin
                    n_mode              = MODE_READY;
                    o_res.command_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
        o_res.mode_code = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_SAFE_STOPPED;
            r_batt_crit <= 1'b0;
            r_ticks     <= '0;
        end else if (i_fire) begin
            r_mode      <= n_mode;
            r_batt_crit <= n_batt_crit;
            r_ticks     <= n_ticks;
        end
    end
endmodule
